[src/fpp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_pkg: shared constants for the face point projector
// Holds the register indexes, reset values, seed codes and the face height
// table that is used by the front end.
// ----------------------------------------------------------------------------
package fpp_pkg;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_FREQUENCY = 2'd0;
   localparam logic [1:0] CSR_SEED      = 2'd1;

   // Reset values of the configuration registers.
   localparam logic [7:0] FREQUENCY_RESET = 8'd1;
   localparam logic [1:0] SEED_RESET      = 2'd2;

   // Seed solid codes.
   localparam logic [1:0] SEED_TETRA = 2'd0;
   localparam logic [1:0] SEED_OCTA  = 2'd1;
   localparam logic [1:0] SEED_ICOSA = 2'd2;

   // Width of the squared face height, held in Q32.
   localparam int HEIGHT_BITS = 32;

   // Squared face height in Q32; the unused code takes the icosahedron value.
   function automatic logic [HEIGHT_BITS-1:0] height_sq(input logic [1:0] seed);
      logic [HEIGHT_BITS-1:0] h;
      case (seed)
         SEED_TETRA: h = 32'd178956971;
         SEED_OCTA:  h = 32'd715827883;
         SEED_ICOSA: h = 32'd2453178649;
         default:    h = 32'd2453178649;
      endcase
      return h;
   endfunction

endpackage

[src/fpp_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_req_if: grid point request channel
// Carries one grid row and column per transaction.
// ----------------------------------------------------------------------------
interface fpp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] row_index;
   logic [7:0] column_index;

   modport source (output valid, output row_index, output column_index, input ready);
   modport sink   (input valid, input row_index, input column_index, output ready);
endinterface

[src/fpp_rsp_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_rsp_if: projected point response channel
// Carries the three sphere coordinates and the index error flag.
// ----------------------------------------------------------------------------
interface fpp_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] sphere_x;
   logic [15:0] sphere_y;
   logic [15:0] sphere_z;
   logic        index_error;

   modport source (output valid, output sphere_x, output sphere_y, output sphere_z,
                   output index_error, input ready);
   modport sink   (input valid, input sphere_x, input sphere_y, input sphere_z,
                   input index_error, output ready);
endinterface

[src/fpp_csr_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_csr_if: configuration write channel
// Carries a register index and the data to write.
// ----------------------------------------------------------------------------
interface fpp_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[src/fpp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_front: grid check and vector setup
// Four stage pipeline that checks the grid point and forms the squared
// vector terms and their sum for the root stages.
// ----------------------------------------------------------------------------
module fpp_front
   import fpp_pkg::*;
#(
   parameter int FB = 8,
   parameter int NW = 2 * FB + 36,
   parameter int SW = NW + 2
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic [7:0]    row_index,
   input  logic [7:0]    column_index,
   input  logic [7:0]    frequency,
   input  logic [1:0]    seed,
   output logic          out_valid,
   input  logic          out_ready,
   output logic          out_err,
   output logic [SW-1:0] out_s,
   output logic [NW-1:0] out_nx,
   output logic [NW-1:0] out_ny,
   output logic [NW-1:0] out_nz
);

   logic en;
   logic [19:0] i_ext, j_ext, f_ext;
   logic [FB-1:0] i_m, j_m, f_m;
   logic err_in;

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic e1_ff, e2_ff, e3_ff, e4_ff;
   logic [FB-1:0] i1_ff, j1_ff, f1_ff;
   logic [1:0] seed1_ff;

   logic [FB+1:0] u;
   logic [2*FB-1:0] ii;
   logic [2*FB+3:0] u2_ff;
   logic [2*FB+1:0] i3_ff;
   logic [2*FB-1:0] f2_ff;
   logic [HEIGHT_BITS-1:0] h_ff;

   logic [2*FB+HEIGHT_BITS-1:0] fh;
   logic [NW-1:0] nx_ff, ny_ff, nz_ff;
   logic [NW-1:0] nx4_ff, ny4_ff, nz4_ff;
   logic [SW-1:0] s_ff;

   // The whole pipeline advances unless the last stage is blocked.
   assign en       = !v4_ff || out_ready;
   assign in_ready = en;

   // Only the low bits of the indexes and frequency take part.
   assign i_ext = {12'b0, row_index};
   assign j_ext = {12'b0, column_index};
   assign f_ext = {12'b0, frequency};
   assign i_m   = i_ext[FB-1:0];
   assign j_m   = j_ext[FB-1:0];
   assign f_m   = f_ext[FB-1:0];
   assign err_in = (f_m == '0) || (i_m > f_m) ||
                   (({1'b0, i_m} + {1'b0, j_m}) > {1'b0, f_m});

   // Stage products.
   assign u  = {2'b0, i1_ff} + {1'b0, j1_ff, 1'b0};
   assign ii = i1_ff * i1_ff;
   assign fh = f2_ff * h_ff;

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   // Payload stages.
   always_ff @(posedge clock) begin
      if (en) begin
         i1_ff    <= i_m;
         j1_ff    <= j_m;
         f1_ff    <= f_m;
         seed1_ff <= seed;
         e1_ff    <= err_in;

         u2_ff <= u * u;
         i3_ff <= {2'b0, ii} + {1'b0, ii, 1'b0};
         f2_ff <= f1_ff * f1_ff;
         h_ff  <= height_sq(seed1_ff);
         e2_ff <= e1_ff;

         nx_ff <= {u2_ff, 32'b0};
         ny_ff <= {2'b0, i3_ff, 32'b0};
         nz_ff <= {2'b0, fh, 2'b0};
         e3_ff <= e2_ff;

         s_ff   <= {2'b0, nx_ff} + {2'b0, ny_ff} + {2'b0, nz_ff};
         nx4_ff <= nx_ff;
         ny4_ff <= ny_ff;
         nz4_ff <= nz_ff;
         e4_ff  <= e3_ff;
      end
   end

   assign out_valid = v4_ff;
   assign out_err   = e4_ff;
   assign out_s     = s_ff;
   assign out_nx    = nx4_ff;
   assign out_ny    = ny4_ff;
   assign out_nz    = nz4_ff;

endmodule

[src/fpp_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_queue: two entry queue
// Decouples the front end from the root stages so each can stall alone.
// ----------------------------------------------------------------------------
module fpp_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic [WIDTH-1:0] mem_ff [2];
   logic wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   logic push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = mem_ff[rd_ptr_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   // Pointers and fill level.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         if (push && !pop) count_ff <= count_ff + 2'd1;
         else if (pop && !push) count_ff <= count_ff - 2'd1;
      end
   end

   // Storage.
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= in_data;
   end

endmodule

[src/fpp_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpp_back: pipelined root of the coordinate ratios
// One result bit per stage for three lanes, by shift and add updates of the
// exact rounding test, followed by the output register.
// ----------------------------------------------------------------------------
module fpp_back
   import fpp_pkg::*;
#(
   parameter int FB = 8,
   parameter int F  = 15,
   parameter int NW = 2 * FB + 36,
   parameter int SW = NW + 2
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  logic          in_err,
   input  logic [SW-1:0] in_s,
   input  logic [NW-1:0] in_nx,
   input  logic [NW-1:0] in_ny,
   input  logic [NW-1:0] in_nz,
   output logic          out_valid,
   input  logic          out_ready,
   output logic [15:0]   sphere_x,
   output logic [15:0]   sphere_y,
   output logic [15:0]   sphere_z,
   output logic          index_error
);

   localparam int W = NW + 2 * F + 9;
   localparam int NS = F + 2;

   logic en;
   logic v_ff   [NS];
   logic err_ff [NS];
   logic [SW-1:0] s_ff [NS];
   logic [F:0] q_ff [NS][3];
   logic signed [W-1:0] e_ff [NS][3];
   logic signed [W-1:0] qs_ff [NS][3];

   logic [NW-1:0] n_in [3];
   logic [F:0] q_in [NS][3];
   logic signed [W-1:0] e_in [NS][3];
   logic signed [W-1:0] qs_in [NS][3];

   logic out_v_ff;
   logic [15:0] x_ff, y_ff, z_ff;
   logic err_out_ff;
   logic [47:0] q_ext [3];

   assign en       = !out_v_ff || out_ready;
   assign in_ready = en;

   assign n_in[0] = in_nx;
   assign n_in[1] = in_ny;
   assign n_in[2] = in_nz;

   // Entry values: remainder starts at N scaled by 2^(2F+2).
   for (genvar l = 0; l < 3; l++) begin : g_init
      assign q_in[0][l]  = '0;
      assign e_in[0][l]  = {{(W-NW){1'b0}}, n_in[l]} <<< (2 * F + 2);
      assign qs_in[0][l] = '0;
   end

   // One stage decides bit B of each coordinate.
   for (genvar k = 0; k <= F; k++) begin : g_stage
      localparam int B = F - k;
      for (genvar l = 0; l < 3; l++) begin : g_lane
         logic signed [W-1:0] sw, t_val;
         logic take;
         assign sw    = {{(W-SW){1'b0}}, s_ff[k]};
         assign t_val = (qs_ff[k][l] <<< (B + 3)) - (qs_ff[k][l] <<< 2)
                      + (sw <<< (2 * B + 2)) - (sw <<< (B + 2)) + sw;
         // A candidate above one is never taken.
         assign take  = !q_ff[k][l][F] && (t_val <= e_ff[k][l]);
         assign q_in[k+1][l]  = take ? (q_ff[k][l] | ((F+1)'(1) << B)) : q_ff[k][l];
         assign e_in[k+1][l]  = take ? (e_ff[k][l] - (qs_ff[k][l] <<< (B + 3))
                                        - (sw <<< (2 * B + 2))) : e_ff[k][l];
         assign qs_in[k+1][l] = take ? (qs_ff[k][l] + (sw <<< B)) : qs_ff[k][l];
      end
   end

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NS; k++) v_ff[k] <= 1'b0;
         out_v_ff <= 1'b0;
      end else if (en) begin
         v_ff[0] <= in_valid;
         for (int k = 1; k < NS; k++) v_ff[k] <= v_ff[k-1];
         out_v_ff <= v_ff[NS-1];
      end
   end

   // Stage payload.
   always_ff @(posedge clock) begin
      if (en) begin
         err_ff[0] <= in_err;
         s_ff[0]   <= in_s;
         for (int k = 1; k < NS; k++) begin
            err_ff[k] <= err_ff[k-1];
            s_ff[k]   <= s_ff[k-1];
         end
         for (int k = 0; k < NS; k++) begin
            for (int l = 0; l < 3; l++) begin
               q_ff[k][l]  <= q_in[k][l];
               e_ff[k][l]  <= e_in[k][l];
               qs_ff[k][l] <= qs_in[k][l];
            end
         end
      end
   end

   // Output register: coordinates are forced to zero off the grid.
   for (genvar l = 0; l < 3; l++) begin : g_ext
      assign q_ext[l] = {{(47 - F){1'b0}}, q_ff[NS-1][l]};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         err_out_ff <= err_ff[NS-1];
         x_ff <= err_ff[NS-1] ? 16'd0 : q_ext[0][15:0];
         y_ff <= err_ff[NS-1] ? 16'd0 : q_ext[1][15:0];
         z_ff <= err_ff[NS-1] ? 16'd0 : q_ext[2][15:0];
      end
   end

   assign out_valid   = out_v_ff;
   assign sphere_x    = x_ff;
   assign sphere_y    = y_ff;
   assign sphere_z    = z_ff;
   assign index_error = err_out_ff;

endmodule

[src/geodesic_face_point_projector.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geodesic_face_point_projector: grid point to unit sphere projection
// Takes a face grid point and gives its rounded coordinates on the sphere.
// ----------------------------------------------------------------------------
// The block accepts one grid point per clock cycle while the response side
// does not stall, and returns one response per point, in order. A point
// passes through four front end stages, the queue, an entry register and
// one root stage per result bit (COORD_FRAC_BITS + 2 stages in all) and the
// output register. The rate is set by the root pipeline, which decides one
// bit of all three coordinates in each stage. Points off the triangular
// grid, or any point at frequency zero, give index_error with zero
// coordinates. Configuration writes are always taken and should be made
// while idle.
module geodesic_face_point_projector
   import fpp_pkg::*;
#(
   parameter int FREQ_BITS       = 8,
   parameter int COORD_FRAC_BITS = 15
) (
   input  logic      clock,
   input  logic      reset,
   fpp_req_if.sink   req_bus,
   fpp_rsp_if.source rsp_bus,
   fpp_csr_if.sink   csr_bus
);

   localparam int NW = 2 * FREQ_BITS + 36;
   localparam int SW = NW + 2;
   localparam int QW = 1 + SW + 3 * NW;

   logic [7:0] freq_ff;
   logic [1:0] seed_ff;

   logic f_valid, f_ready, f_err;
   logic [SW-1:0] f_s;
   logic [NW-1:0] f_nx, f_ny, f_nz;
   logic q_valid, q_ready;
   logic [QW-1:0] q_out;

   // Configuration registers.
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         freq_ff <= FREQUENCY_RESET;
         seed_ff <= SEED_RESET;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_FREQUENCY: freq_ff <= csr_bus.data;
            CSR_SEED:      seed_ff <= csr_bus.data[1:0];
            default:       ;
         endcase
      end
   end

   // Front end: grid check and vector terms.
   fpp_front #(.FB(FREQ_BITS), .NW(NW), .SW(SW)) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_bus.valid),
      .in_ready     (req_bus.ready),
      .row_index    (req_bus.row_index),
      .column_index (req_bus.column_index),
      .frequency    (freq_ff),
      .seed         (seed_ff),
      .out_valid    (f_valid),
      .out_ready    (f_ready),
      .out_err      (f_err),
      .out_s        (f_s),
      .out_nx       (f_nx),
      .out_ny       (f_ny),
      .out_nz       (f_nz)
   );

   // Queue between the front end and the root stages.
   fpp_queue #(.WIDTH(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_data   ({f_err, f_s, f_nx, f_ny, f_nz}),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_data  (q_out)
   );

   // Root stages and output register.
   fpp_back #(.FB(FREQ_BITS), .F(COORD_FRAC_BITS), .NW(NW), .SW(SW)) u_back (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (q_valid),
      .in_ready    (q_ready),
      .in_err      (q_out[QW-1]),
      .in_s        (q_out[QW-2 -: SW]),
      .in_nx       (q_out[3*NW-1 -: NW]),
      .in_ny       (q_out[2*NW-1 -: NW]),
      .in_nz       (q_out[NW-1:0]),
      .out_valid   (rsp_bus.valid),
      .out_ready   (rsp_bus.ready),
      .sphere_x    (rsp_bus.sphere_x),
      .sphere_y    (rsp_bus.sphere_y),
      .sphere_z    (rsp_bus.sphere_z),
      .index_error (rsp_bus.index_error)
   );

`ifndef ASSERT_OFF
   // An off-grid response carries zero coordinates.
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.index_error |->
         rsp_bus.sphere_x == 16'd0 && rsp_bus.sphere_y == 16'd0 &&
         rsp_bus.sphere_z == 16'd0)
      else $error("off-grid response with nonzero coordinates");

   // Reset restores the register defaults.
   a_cfg_reset: assert property (@(posedge clock)
      reset |=> freq_ff == FREQUENCY_RESET && seed_ff == SEED_RESET)
      else $error("configuration registers not at reset values");

   // No coordinate of a valid point exceeds one.
   a_coord_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.index_error && COORD_FRAC_BITS < 16 |->
         {16'd0, rsp_bus.sphere_x} <= (32'd1 << COORD_FRAC_BITS) &&
         {16'd0, rsp_bus.sphere_y} <= (32'd1 << COORD_FRAC_BITS) &&
         {16'd0, rsp_bus.sphere_z} <= (32'd1 << COORD_FRAC_BITS))
      else $error("coordinate above one");
`endif

endmodule
